// ----- hw/rtl/sste_pkg.sv -----
// shared types and codes for the static search table engine
`default_nettype none

package sste_pkg;

  localparam int KeyW = 8;
  localparam int OpW  = 3;

  // request opcodes
  localparam logic [OpW-1:0] OP_CLEAR = 3'd0;
  localparam logic [OpW-1:0] OP_LOAD  = 3'd1;
  localparam logic [OpW-1:0] OP_SORT  = 3'd2;
  localparam logic [OpW-1:0] OP_SEQ   = 3'd3;
  localparam logic [OpW-1:0] OP_BIN   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEQ_RD,
    ST_SEQ_CMP,
    ST_BIN_RD,
    ST_BIN_CMP,
    ST_SORT_RD_I,
    ST_SORT_LD_I,
    ST_SORT_RD_J,
    ST_SORT_CMP,
    ST_SORT_SW1,
    ST_SORT_SW2,
    ST_FINISH
  } state_t;

  // datapath micro operations
  typedef enum logic [4:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_CLEAR,
    DP_LOAD,
    DP_RES_ZERO,
    DP_SEQ_INIT,
    DP_SEQ_RD,
    DP_SEQ_STEP,
    DP_BIN_INIT,
    DP_BIN_RD,
    DP_BIN_STEP,
    DP_SORT_INIT,
    DP_SORT_RD_I,
    DP_SORT_LD_I,
    DP_SORT_RD_J,
    DP_SORT_CMP,
    DP_SORT_SW1,
    DP_SORT_SW2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic           seq_done;
    logic           key_hit;
    logic           bin_done;
    logic           sort_skip;
    logic           sort_j_last;
    logic           sort_i_last;
    logic           out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sste_ctrl.sv -----
// sequencing state machine for the static search table engine
`default_nettype none

module sste_ctrl import sste_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts.opcode)
          OP_SEQ:  state_nxt = ST_SEQ_RD;
          OP_BIN:  state_nxt = ST_BIN_RD;
          OP_SORT: state_nxt = sts.sort_skip ? ST_FINISH : ST_SORT_RD_I;
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_SEQ_RD:    state_nxt = sts.seq_done ? ST_FINISH : ST_SEQ_CMP;
      ST_SEQ_CMP:   state_nxt = sts.key_hit ? ST_FINISH : ST_SEQ_RD;
      ST_BIN_RD:    state_nxt = sts.bin_done ? ST_FINISH : ST_BIN_CMP;
      ST_BIN_CMP:   state_nxt = sts.key_hit ? ST_FINISH : ST_BIN_RD;
      ST_SORT_RD_I: state_nxt = ST_SORT_LD_I;
      ST_SORT_LD_I: state_nxt = ST_SORT_RD_J;
      ST_SORT_RD_J: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP:  state_nxt = sts.sort_j_last ? ST_SORT_SW1 : ST_SORT_RD_J;
      ST_SORT_SW1:  state_nxt = ST_SORT_SW2;
      ST_SORT_SW2:  state_nxt = sts.sort_i_last ? ST_FINISH : ST_SORT_RD_I;
      ST_FINISH: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = DP_NONE;
    cmd.emit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) cmd.op = DP_ACCEPT;
      end
      ST_DISPATCH: begin
        unique case (sts.opcode)
          OP_CLEAR: cmd.op = DP_CLEAR;
          OP_LOAD:  cmd.op = DP_LOAD;
          OP_SORT:  cmd.op = DP_SORT_INIT;
          OP_SEQ:   cmd.op = DP_SEQ_INIT;
          OP_BIN:   cmd.op = DP_BIN_INIT;
          default:  cmd.op = DP_RES_ZERO;
        endcase
      end
      ST_SEQ_RD: begin
        if (!sts.seq_done) cmd.op = DP_SEQ_RD;
      end
      ST_SEQ_CMP:   cmd.op = DP_SEQ_STEP;
      ST_BIN_RD: begin
        if (!sts.bin_done) cmd.op = DP_BIN_RD;
      end
      ST_BIN_CMP:   cmd.op = DP_BIN_STEP;
      ST_SORT_RD_I: cmd.op = DP_SORT_RD_I;
      ST_SORT_LD_I: cmd.op = DP_SORT_LD_I;
      ST_SORT_RD_J: cmd.op = DP_SORT_RD_J;
      ST_SORT_CMP:  cmd.op = DP_SORT_CMP;
      ST_SORT_SW1:  cmd.op = DP_SORT_SW1;
      ST_SORT_SW2:  cmd.op = DP_SORT_SW2;
      ST_FINISH:    cmd.emit = !sts.out_busy;
      default:      cmd.op = DP_NONE;
    endcase
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result emitted into an occupied output register");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_DISPATCH)
    else $error("accepted request not dispatched");

  a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH && !sts.out_busy |=> state_r == ST_IDLE)
    else $error("finish did not return to idle");

endmodule

`default_nettype wire

// ----- hw/rtl/sste_dp.sv -----
// key table memory, search and sort registers, result register
`default_nettype none

module sste_dp import sste_pkg::*; #(
  parameter  int TABLE_DEPTH = 64,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int BW = CW + 1
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cmd_t                   cmd,
  input  wire        [OpW-1:0]   in_opcode,
  input  wire signed [KeyW-1:0]  in_key_value,
  input  wire                    out_ready,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic       [CW-1:0]    out_position,
  output logic                   out_found,
  output logic                   out_status
);

  logic signed [KeyW-1:0] mem [TABLE_DEPTH];

  logic        [OpW-1:0]  op_r;
  logic signed [KeyW-1:0] key_r;
  logic signed [KeyW-1:0] rdata_r;
  logic        [CW-1:0]   count_r;
  logic        [CW-1:0]   idx_r;
  logic        [BW-1:0]   low_r;
  logic        [BW-1:0]   high_r;
  logic        [CW-1:0]   mid_r;
  logic        [CW-1:0]   i_r;
  logic        [CW-1:0]   j_r;
  logic        [CW-1:0]   k_r;
  logic signed [KeyW-1:0] min_r;
  logic signed [KeyW-1:0] keyi_r;
  logic        [CW-1:0]   res_pos_r;
  logic                   res_found_r;
  logic                   res_status_r;
  logic                   out_valid_r;
  logic        [CW-1:0]   out_position_r;
  logic                   out_found_r;
  logic                   out_status_r;

  logic                   full;
  logic                   key_hit;
  logic        [BW-1:0]   mid_w;
  logic        [AW-1:0]   rd_addr;
  logic                   we;
  logic        [AW-1:0]   wr_addr;
  logic signed [KeyW-1:0] wr_data;

  assign full    = count_r == CW'(TABLE_DEPTH);
  assign key_hit = key_r == rdata_r;
  assign mid_w   = low_r + ((high_r - low_r) >> 1);

  always_comb begin
    case (cmd.op)
      DP_SEQ_RD:    rd_addr = AW'(idx_r - CW'(1));
      DP_BIN_RD:    rd_addr = AW'(mid_w - BW'(1));
      DP_SORT_RD_I: rd_addr = AW'(i_r - CW'(1));
      DP_SORT_RD_J: rd_addr = AW'(j_r - CW'(1));
      default:      rd_addr = '0;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wr_data = key_r;
    case (cmd.op)
      DP_LOAD: begin
        we      = !full;
        wr_addr = AW'(count_r);
        wr_data = key_r;
      end
      DP_SORT_SW1: begin
        we      = 1'b1;
        wr_addr = AW'(k_r - CW'(1));
        wr_data = keyi_r;
      end
      DP_SORT_SW2: begin
        we      = 1'b1;
        wr_addr = AW'(i_r - CW'(1));
        wr_data = min_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == DP_CLEAR) begin
        count_r <= '0;
      end else if (cmd.op == DP_LOAD && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_ACCEPT: begin
        op_r  <= in_opcode;
        key_r <= in_key_value;
      end
      DP_CLEAR, DP_RES_ZERO: begin
        res_pos_r    <= '0;
        res_found_r  <= 1'b0;
        res_status_r <= 1'b0;
      end
      DP_LOAD: begin
        res_pos_r    <= full ? '0 : count_r + CW'(1);
        res_found_r  <= 1'b0;
        res_status_r <= full;
      end
      DP_SEQ_INIT: begin
        idx_r        <= count_r;
        res_pos_r    <= '0;
        res_found_r  <= 1'b0;
        res_status_r <= 1'b0;
      end
      DP_SEQ_STEP: begin
        if (key_hit) begin
          res_pos_r   <= idx_r;
          res_found_r <= 1'b1;
        end else begin
          idx_r <= idx_r - CW'(1);
        end
      end
      DP_BIN_INIT: begin
        low_r        <= BW'(1);
        high_r       <= {1'b0, count_r};
        res_pos_r    <= '0;
        res_found_r  <= 1'b0;
        res_status_r <= 1'b0;
      end
      DP_BIN_RD: mid_r <= CW'(mid_w);
      DP_BIN_STEP: begin
        if (key_hit) begin
          res_pos_r   <= mid_r;
          res_found_r <= 1'b1;
        end else if (key_r < rdata_r) begin
          high_r <= {1'b0, mid_r} - BW'(1);
        end else begin
          low_r <= {1'b0, mid_r} + BW'(1);
        end
      end
      DP_SORT_INIT: begin
        i_r          <= CW'(1);
        res_pos_r    <= '0;
        res_found_r  <= 1'b0;
        res_status_r <= 1'b0;
      end
      DP_SORT_LD_I: begin
        min_r  <= rdata_r;
        keyi_r <= rdata_r;
        k_r    <= i_r;
        j_r    <= i_r + CW'(1);
      end
      DP_SORT_CMP: begin
        if (rdata_r < min_r) begin
          min_r <= rdata_r;
          k_r   <= j_r;
        end
        if (j_r != count_r) j_r <= j_r + CW'(1);
      end
      DP_SORT_SW2: i_r <= i_r + CW'(1);
      default: ;
    endcase
    if (cmd.emit) begin
      out_position_r <= res_pos_r;
      out_found_r    <= res_found_r;
      out_status_r   <= res_status_r;
    end
  end

  always_comb begin
    sts.opcode      = op_r;
    sts.seq_done    = idx_r == '0;
    sts.key_hit     = key_hit;
    sts.bin_done    = low_r > high_r;
    sts.sort_skip   = count_r < CW'(2);
    sts.sort_j_last = j_r == count_r;
    sts.sort_i_last = (i_r + CW'(1)) == count_r;
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_found    = out_found_r;
  assign out_status   = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_position_r != '0)
    else $error("hit reported at position zero");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_position_r == '0 && !out_found_r)
    else $error("ignored load reported a position");

endmodule

`default_nettype wire

// ----- hw/rtl/static_search_table_engine.sv -----
// top level of the static search table engine
`default_nettype none

// Keeps up to TABLE_DEPTH signed 8-bit keys in positions 1..count and runs
// one request at a time: clear, load (append), sort ascending, sequential
// search (highest matching position) or binary search (first probe that
// matches). Every request gives exactly one result. All table traffic goes
// through a single memory with one write and one registered read port, and
// that port sets the timing: each table read is split into an address step
// and a compare step. Clear, load and unused opcodes go straight from
// dispatch to the result; sequential search scans down from the last entry
// until it hits or runs out of entries; binary search probes until it hits
// or its range is empty; sort is a selection sort with an outer pass for
// every position but the last and a compare per remaining entry, skipped
// for fewer than two entries. The result sits in an output register, so a
// new request is taken while the last result still waits; its result then
// waits for the register to drain. There is no clearing pass after reset:
// the table reads only entries that a load wrote, and only the entry count
// and the output valid flag are reset.

module static_search_table_engine import sste_pkg::*; #(
  parameter  int TABLE_DEPTH = 64,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // request channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire       [OpW-1:0]   in_opcode,
  input  wire signed [KeyW-1:0] in_key_value,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic      [CW-1:0]    out_position,
  output logic                  out_found,
  output logic                  out_status
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one request at a time, steps the table walks
  sste_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: key memory, counters, compare logic and output register
  sste_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_opcode    (in_opcode),
    .in_key_value (in_key_value),
    .out_ready    (out_ready),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_position (out_position),
    .out_found    (out_found),
    .out_status   (out_status)
  );

endmodule

`default_nettype wire
